// ===== design/pls_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pls_pkg
// shared types and codes of the positional list store: command and status
// codes, operation kinds, sequencer states and the transfer payloads of both channels
// ----------------------------------------------------------------------------
package pls_pkg;

    localparam logic [3:0] CMD_PUSH_FRONT = 4'd0;
    localparam logic [3:0] CMD_PUSH_BACK  = 4'd1;
    localparam logic [3:0] CMD_POP_FRONT  = 4'd2;
    localparam logic [3:0] CMD_POP_BACK   = 4'd3;
    localparam logic [3:0] CMD_READ_FRONT = 4'd4;
    localparam logic [3:0] CMD_READ_BACK  = 4'd5;
    localparam logic [3:0] CMD_INSERT     = 4'd6;
    localparam logic [3:0] CMD_ERASE      = 4'd7;
    localparam logic [3:0] CMD_GET        = 4'd8;
    localparam logic [3:0] CMD_QUERY      = 4'd9;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_RANGE = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;
    localparam logic [1:0] ST_FULL  = 2'd3;

    typedef enum logic [1:0] {
        OP_NONE,
        OP_INS,
        OP_DEL,
        OP_RD
    } t_op;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SH_RD,
        S_SH_WR,
        S_PUT,
        S_RD,
        S_DONE
    } t_state;

    typedef struct packed {
        logic [3:0]         command;
        logic signed [31:0] value;
        logic [6:0]         position;
    } t_in;

    typedef struct packed {
        logic signed [31:0] read_data;
        logic [1:0]         status;
        logic [6:0]         entry_count;
        logic               is_empty;
    } t_out;

endpackage
`default_nettype wire

// ===== design/pls_mem.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pls_mem
// entry storage: one write port, one read port, registered read data
// ----------------------------------------------------------------------------
module pls_mem #(
    parameter int DEPTH      = 64,
    parameter int DATA_WIDTH = 32
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0]     i_wr_addr,
    input  wire logic [DATA_WIDTH-1:0]        i_wr_data,
    input  wire logic                         i_rd_en,
    input  wire logic [$clog2(DEPTH)-1:0]     i_rd_addr,
    output logic [DATA_WIDTH-1:0]             o_rd_data
);

    logic [DATA_WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule
`default_nettype wire

// ===== design/pls_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pls_ctrl
// command sequencer: decodes a command, moves entries one at a time through
// the storage for insert and erase, reads entries, keeps the count and holds
// the result register
// ----------------------------------------------------------------------------
module pls_ctrl
    import pls_pkg::*;
#(
    parameter int DEPTH      = 64,
    parameter int DATA_WIDTH = 32
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_valid,
    output logic                              o_stall,
    input  wire t_in                          i_item,
    output logic                              o_valid,
    input  wire logic                         i_stall,
    output t_out                              o_result,
    output logic                              o_wr_en,
    output logic [$clog2(DEPTH)-1:0]          o_wr_addr,
    output logic [DATA_WIDTH-1:0]             o_wr_data,
    output logic                              o_rd_en,
    output logic [$clog2(DEPTH)-1:0]          o_rd_addr,
    input  wire logic [DATA_WIDTH-1:0]        i_rd_data
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int EW = CW + 8;

    t_state                r_state, n_state;
    t_op                   r_op, n_op;
    logic [AW-1:0]         r_idx, n_idx;
    logic [AW-1:0]         r_ptr, n_ptr;
    logic [DATA_WIDTH-1:0] r_val, n_val;
    logic [1:0]            r_status, n_status;
    logic [CW-1:0]         r_count, n_count;
    logic                  r_out_valid, n_out_valid;
    t_out                  r_out, n_out;

    logic                     full;
    logic                     empty;
    logic [EW-1:0]            pos_e;
    logic [EW-1:0]            cnt_e;
    logic [DATA_WIDTH+31:0]   val_wide;
    logic [DATA_WIDTH+31:0]   rd_wide;

    assign full     = r_count == CW'(DEPTH);
    assign empty    = r_count == '0;
    assign pos_e    = EW'(i_item.position);
    assign cnt_e    = EW'(r_count);
    assign val_wide = {{DATA_WIDTH{1'b0}}, i_item.value};
    assign rd_wide  = {{32{i_rd_data[DATA_WIDTH-1]}}, i_rd_data};

    always_comb begin
        n_state     = r_state;
        n_op        = r_op;
        n_idx       = r_idx;
        n_ptr       = r_ptr;
        n_val       = r_val;
        n_status    = r_status;
        n_count     = r_count;
        n_out_valid = r_out_valid && i_stall;
        n_out       = r_out;
        o_wr_en     = 1'b0;
        o_wr_addr   = r_ptr;
        o_wr_data   = i_rd_data;
        o_rd_en     = 1'b0;
        o_rd_addr   = r_idx;

        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_val    = val_wide[DATA_WIDTH-1:0];
                    n_status = ST_OK;
                    n_op     = OP_NONE;
                    n_idx    = '0;
                    case (i_item.command)
                        CMD_PUSH_FRONT: begin
                            if (full) n_status = ST_FULL;
                            else n_op = OP_INS;
                        end
                        CMD_PUSH_BACK: begin
                            if (full) begin
                                n_status = ST_FULL;
                            end else begin
                                n_op  = OP_INS;
                                n_idx = AW'(r_count);
                            end
                        end
                        CMD_POP_FRONT: begin
                            if (empty) n_status = ST_EMPTY;
                            else n_op = OP_DEL;
                        end
                        CMD_POP_BACK: begin
                            if (empty) begin
                                n_status = ST_EMPTY;
                            end else begin
                                n_op  = OP_DEL;
                                n_idx = AW'(r_count - CW'(1));
                            end
                        end
                        CMD_READ_FRONT: begin
                            if (empty) n_status = ST_EMPTY;
                            else n_op = OP_RD;
                        end
                        CMD_READ_BACK: begin
                            if (empty) begin
                                n_status = ST_EMPTY;
                            end else begin
                                n_op  = OP_RD;
                                n_idx = AW'(r_count - CW'(1));
                            end
                        end
                        CMD_INSERT: begin
                            if (pos_e == '0 || pos_e > cnt_e + EW'(1)) begin
                                n_status = ST_RANGE;
                            end else if (full) begin
                                n_status = ST_FULL;
                            end else begin
                                n_op  = OP_INS;
                                n_idx = AW'(pos_e - EW'(1));
                            end
                        end
                        CMD_ERASE: begin
                            if (empty) begin
                                n_status = ST_EMPTY;
                            end else if (pos_e == '0 || pos_e > cnt_e) begin
                                n_status = ST_RANGE;
                            end else begin
                                n_op  = OP_DEL;
                                n_idx = AW'(pos_e - EW'(1));
                            end
                        end
                        CMD_GET: begin
                            if (empty) begin
                                n_status = ST_EMPTY;
                            end else if (pos_e >= cnt_e) begin
                                n_status = ST_RANGE;
                            end else begin
                                n_op  = OP_RD;
                                n_idx = AW'(pos_e);
                            end
                        end
                        default: begin
                            n_op = OP_NONE;
                        end
                    endcase

                    case (n_op)
                        OP_INS: begin
                            n_ptr   = AW'(r_count);
                            n_state = (cnt_e > EW'(n_idx)) ? S_SH_RD : S_PUT;
                        end
                        OP_DEL: begin
                            n_ptr = n_idx;
                            if (EW'(n_idx) + EW'(1) < cnt_e) begin
                                n_state = S_SH_RD;
                            end else begin
                                n_state = S_DONE;
                                n_count = r_count - CW'(1);
                            end
                        end
                        OP_RD: begin
                            n_state = S_RD;
                        end
                        default: begin
                            n_state = S_DONE;
                        end
                    endcase
                end
            end
            S_SH_RD: begin
                o_rd_en   = 1'b1;
                o_rd_addr = (r_op == OP_INS) ? r_ptr - AW'(1) : r_ptr + AW'(1);
                n_state   = S_SH_WR;
            end
            S_SH_WR: begin
                o_wr_en   = 1'b1;
                o_wr_addr = r_ptr;
                o_wr_data = i_rd_data;
                if (r_op == OP_INS) begin
                    n_ptr   = r_ptr - AW'(1);
                    n_state = (r_ptr - AW'(1) > r_idx) ? S_SH_RD : S_PUT;
                end else begin
                    n_ptr = r_ptr + AW'(1);
                    if (EW'(r_ptr) + EW'(2) < cnt_e) begin
                        n_state = S_SH_RD;
                    end else begin
                        n_state = S_DONE;
                        n_count = r_count - CW'(1);
                    end
                end
            end
            S_PUT: begin
                o_wr_en   = 1'b1;
                o_wr_addr = r_idx;
                o_wr_data = r_val;
                n_count   = r_count + CW'(1);
                n_state   = S_DONE;
            end
            S_RD: begin
                o_rd_en   = 1'b1;
                o_rd_addr = r_idx;
                n_state   = S_DONE;
            end
            S_DONE: begin
                if (!r_out_valid || !i_stall) begin
                    n_out_valid       = 1'b1;
                    n_out.read_data   = (r_op == OP_RD) ? rd_wide[31:0] : '0;
                    n_out.status      = r_status;
                    n_out.entry_count = 7'(r_count);
                    n_out.is_empty    = r_count == '0;
                    n_state           = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op     <= n_op;
        r_idx    <= n_idx;
        r_ptr    <= n_ptr;
        r_val    <= n_val;
        r_status <= n_status;
        r_out    <= n_out;
    end

    assign o_stall  = r_state != S_IDLE;
    assign o_valid  = r_out_valid;
    assign o_result = r_out;

endmodule
`default_nettype wire

// ===== design/positional_list_store_unit.sv =====
`default_nettype none
// query, rejected commands and pop back go straight from decode to the result state
// read front, read back, get: one storage read state (S_RD) before the result state
// insert or push at index k of n entries moves n-k entries before the new word is put; erase at k moves n-k-1
// each moved entry passes through a read state (S_SH_RD) and a write state (S_SH_WR) on the single storage port pair
// one command at a time; the next transfer is taken once the result is registered
// reset clears the count and the sequencer; entry contents stay as they were
// ----------------------------------------------------------------------------
// positional_list_store_unit
// bounded ordered list of signed words with push, pop, read, positional
// insert, erase and get; entries kept packed in one storage array
// ----------------------------------------------------------------------------
module positional_list_store_unit
    import pls_pkg::*;
#(
    parameter int DEPTH      = 64,
    parameter int DATA_WIDTH = 32
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_valid,
    output logic      o_stall,
    input  wire t_in  i_item,
    output logic      o_valid,
    input  wire logic i_stall,
    output t_out      o_result
);

    localparam int AW = $clog2(DEPTH);

    logic                  wr_en;
    logic [AW-1:0]         wr_addr;
    logic [DATA_WIDTH-1:0] wr_data;
    logic                  rd_en;
    logic [AW-1:0]         rd_addr;
    logic [DATA_WIDTH-1:0] rd_data;

    pls_ctrl #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .o_stall   (o_stall),
        .i_item    (i_item),
        .o_valid   (o_valid),
        .i_stall   (i_stall),
        .o_result  (o_result),
        .o_wr_en   (wr_en),
        .o_wr_addr (wr_addr),
        .o_wr_data (wr_data),
        .o_rd_en   (rd_en),
        .o_rd_addr (rd_addr),
        .i_rd_data (rd_data)
    );

    pls_mem #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_mem (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

endmodule
`default_nettype wire

// ===== design/pls_chk.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pls_chk
// port checker for the positional list store, bound to the top level
// ----------------------------------------------------------------------------
module pls_chk
    import pls_pkg::*;
#(
    parameter int DEPTH = 64
) (
    input wire logic i_clk,
    input wire logic i_rst_n,
    input wire logic o_valid,
    input wire logic i_stall,
    input wire t_out o_result
);

    // stalled result transfer holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_result))
        else $error("result changed while stalled");

    a_no_valid_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid right after reset");

    a_empty_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_result.is_empty == (o_result.entry_count == 7'd0)))
        else $error("empty flag disagrees with count");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> 32'(o_result.entry_count) <= DEPTH)
        else $error("count above depth");

    a_empty_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_result.status == ST_EMPTY
            |-> o_result.is_empty && o_result.read_data == 32'sd0)
        else $error("empty status on non-empty list");

endmodule

bind positional_list_store_unit pls_chk #(.DEPTH(DEPTH)) u_chk (.*);
`default_nettype wire
